>>> rtl/core/rpn_pkg.sv
`timescale 1ns / 1ps

package rpn_pkg;

    // Data and stack geometry
    localparam int DATA_W      = 32;
    localparam int STACK_DEPTH = 16;
    localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int DIV_CNT_W   = $clog2(DATA_W);
    localparam int FUNC_W      = 3;
    localparam int STATUS_W    = 3;

    // Token codes
    localparam logic [FUNC_W-1:0] FN_PUSH = 3'd0;
    localparam logic [FUNC_W-1:0] FN_ADD  = 3'd1;
    localparam logic [FUNC_W-1:0] FN_SUB  = 3'd2;
    localparam logic [FUNC_W-1:0] FN_MUL  = 3'd3;
    localparam logic [FUNC_W-1:0] FN_DIV  = 3'd4;
    localparam logic [FUNC_W-1:0] FN_END  = 3'd5;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FEW      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DIVZERO  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_INVALID  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DEPTH    = 3'd4;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd5;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_OPER,
        S_DIV,
        S_DIV_WB,
        S_EMIT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic                accept;
        logic                push;
        logic                set_err;
        logic [STATUS_W-1:0] err_code;
        logic                rd_below;
        logic                alu_wb;
        logic                div_start;
        logic                div_step;
        logic                div_wb;
        logic                emit;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic is_end;
        logic is_push;
        logic is_div;
        logic invalid;
        logic err_set;
        logic full;
        logic few;
        logic a_zero;
        logic div_last;
        logic out_free;
    } t_dp_status;

endpackage

>>> rtl/core/rpn_stack_evaluator.sv
`timescale 1ns / 1ps

// Reverse Polish integer evaluator on a 16-entry operand stack.
// Input channel (i_in_valid / o_in_stall) carries one token per item:
// i_func selects push, add, subtract, multiply, divide, end or invalid,
// i_value is the number for a push. An item is taken when valid is high
// and stall is low.
// Output channel (o_out_valid / i_out_stall) carries one item per end
// token: o_status and o_result (result is zero unless status is ok).
// Divide uses the one-bit-per-cycle restoring divider. Tokens are
// handled one at a time since each depends on the stack left by the
// one before.
// The result sits in an output register; while it waits the block keeps
// taking tokens, and only a following end token waits for the register
// to empty.
// Reset empties the stack, clears the error and the output valid flag.
module rpn_stack_evaluator (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [rpn_pkg::FUNC_W-1:0]         i_func,
    input  logic signed [rpn_pkg::DATA_W-1:0]  i_value,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [rpn_pkg::STATUS_W-1:0]       o_status,
    output logic signed [rpn_pkg::DATA_W-1:0]  o_result
);
    import rpn_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    // Sequencer
    rpn_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // Stack, ALU, divider and output register
    rpn_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_func        (i_func),
        .i_value       (i_value),
        .i_cmd         (w_cmd),
        .o_status_bits (w_status),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_status      (o_status),
        .o_result      (o_result)
    );

endmodule

>>> rtl/core/rpn_ctrl.sv
`timescale 1ns / 1ps

module rpn_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  rpn_pkg::t_dp_status i_status,
    output rpn_pkg::t_dp_cmd    o_cmd
);
    import rpn_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_status.is_end) begin
                    n_state = S_EMIT;
                end else if (i_status.err_set || i_status.is_push || i_status.invalid ||
                             i_status.few || (i_status.is_div && i_status.a_zero)) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_OPER;
                end
            end
            S_OPER: begin
                n_state = i_status.is_div ? S_DIV : S_IDLE;
            end
            S_DIV: begin
                if (i_status.div_last) begin
                    n_state = S_DIV_WB;
                end
            end
            S_DIV_WB: begin
                n_state = S_IDLE;
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Command decode
    always_comb begin
        o_cmd = '0;
        o_cmd.err_code = ST_OK;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.accept = i_in_valid;
            end
            S_DECODE: begin
                // first error wins; later tokens are dropped until the end marker
                if (i_status.is_end || i_status.err_set) begin
                    o_cmd.set_err = 1'b0;
                end else if (i_status.is_push) begin
                    if (i_status.full) begin
                        o_cmd.set_err  = 1'b1;
                        o_cmd.err_code = ST_OVERFLOW;
                    end else begin
                        o_cmd.push = 1'b1;
                    end
                end else if (i_status.invalid) begin
                    o_cmd.set_err  = 1'b1;
                    o_cmd.err_code = ST_INVALID;
                end else if (i_status.few) begin
                    o_cmd.set_err  = 1'b1;
                    o_cmd.err_code = ST_FEW;
                end else if (i_status.is_div && i_status.a_zero) begin
                    o_cmd.set_err  = 1'b1;
                    o_cmd.err_code = ST_DIVZERO;
                end else begin
                    o_cmd.rd_below = 1'b1;
                end
            end
            S_OPER: begin
                o_cmd.div_start = i_status.is_div;
                o_cmd.alu_wb    = !i_status.is_div;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
            end
            S_DIV_WB: begin
                o_cmd.div_wb = 1'b1;
            end
            S_EMIT: begin
                o_cmd.emit = i_status.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

>>> rtl/core/rpn_dp.sv
`timescale 1ns / 1ps

module rpn_dp (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic [rpn_pkg::FUNC_W-1:0]              i_func,
    input  logic signed [rpn_pkg::DATA_W-1:0]       i_value,
    input  rpn_pkg::t_dp_cmd                        i_cmd,
    output rpn_pkg::t_dp_status                     o_status_bits,
    input  logic                                    i_out_stall,
    output logic                                    o_out_valid,
    output logic [rpn_pkg::STATUS_W-1:0]            o_status,
    output logic signed [rpn_pkg::DATA_W-1:0]       o_result
);
    import rpn_pkg::*;

    // Token and stack state
    logic [FUNC_W-1:0]   r_func;
    logic [DATA_W-1:0]   r_value;
    logic [DATA_W-1:0]   r_tos;
    logic [DATA_W-1:0]   r_rdata;
    logic [DEPTH_W-1:0]  r_depth;
    logic [STATUS_W-1:0] r_err;
    logic [DATA_W-1:0]   r_stack [STACK_DEPTH];

    // Divider state
    logic [DATA_W-1:0]   r_rem;
    logic [DATA_W-1:0]   r_quo;
    logic [DATA_W-1:0]   r_dvs;
    logic                r_neg;
    logic [DIV_CNT_W-1:0] r_cnt;

    // Output register
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [DATA_W-1:0]   r_out_result;

    logic [DEPTH_W-1:0]  w_below;
    logic [ADDR_W-1:0]   w_wr_addr;
    logic [DATA_W-1:0]   w_alu;
    logic [DATA_W-1:0]   w_wb_data;
    logic                w_wr_en;
    logic [DATA_W:0]     w_rem_sh;
    logic [DATA_W:0]     w_trial;
    logic [DATA_W-1:0]   w_abs_b;
    logic [DATA_W-1:0]   w_abs_a;
    logic [DATA_W-1:0]   w_quo_fix;
    logic                w_final_ok;

    assign w_below = r_depth - DEPTH_W'(2);

    // Status to the controller
    always_comb begin
        o_status_bits.is_end   = (r_func == FN_END);
        o_status_bits.is_push  = (r_func == FN_PUSH);
        o_status_bits.is_div   = (r_func == FN_DIV);
        o_status_bits.invalid  = (r_func > FN_DIV) && (r_func != FN_END);
        o_status_bits.err_set  = (r_err != ST_OK);
        o_status_bits.full     = (r_depth >= DEPTH_W'(STACK_DEPTH));
        o_status_bits.few      = (r_depth < DEPTH_W'(2));
        o_status_bits.a_zero   = (r_tos == '0);
        o_status_bits.div_last = (r_cnt == '0);
        o_status_bits.out_free = !r_out_valid || !i_out_stall;
    end

    // Add, subtract, multiply on b (below) and a (top)
    always_comb begin
        case (r_func)
            FN_ADD:  w_alu = r_rdata + r_tos;
            FN_SUB:  w_alu = r_rdata - r_tos;
            default: w_alu = r_rdata * r_tos;
        endcase
    end

    // Divider operand magnitudes and one restoring step
    assign w_abs_b   = r_rdata[DATA_W-1] ? (~r_rdata + DATA_W'(1)) : r_rdata;
    assign w_abs_a   = r_tos[DATA_W-1] ? (~r_tos + DATA_W'(1)) : r_tos;
    assign w_rem_sh  = {r_rem, r_quo[DATA_W-1]};
    assign w_trial   = w_rem_sh - {1'b0, r_dvs};
    assign w_quo_fix = r_neg ? (~r_quo + DATA_W'(1)) : r_quo;

    // Stack write port
    assign w_wr_en   = i_cmd.push || i_cmd.alu_wb || i_cmd.div_wb;
    assign w_wr_addr = i_cmd.push ? r_depth[ADDR_W-1:0] : w_below[ADDR_W-1:0];
    always_comb begin
        if (i_cmd.push) begin
            w_wb_data = r_value;
        end else if (i_cmd.div_wb) begin
            w_wb_data = w_quo_fix;
        end else begin
            w_wb_data = w_alu;
        end
    end

    // Stack memory, registered read of the entry below the top
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_stack[w_wr_addr] <= w_wb_data;
        end
        if (i_cmd.rd_below) begin
            r_rdata <= r_stack[w_below[ADDR_W-1:0]];
        end
    end

    // Token capture and top-of-stack copy
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_func  <= i_func;
            r_value <= i_value;
        end
        if (w_wr_en) begin
            r_tos <= w_wb_data;
        end
    end

    // Depth and error
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= '0;
            r_err   <= ST_OK;
        end else if (i_cmd.emit) begin
            r_depth <= '0;
            r_err   <= ST_OK;
        end else begin
            if (i_cmd.push) begin
                r_depth <= r_depth + DEPTH_W'(1);
            end else if (i_cmd.alu_wb || i_cmd.div_wb) begin
                r_depth <= r_depth - DEPTH_W'(1);
            end
            if (i_cmd.set_err) begin
                r_err <= i_cmd.err_code;
            end
        end
    end

    // Iterative divider, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_rem <= '0;
            r_quo <= w_abs_b;
            r_dvs <= w_abs_a;
            r_neg <= r_rdata[DATA_W-1] ^ r_tos[DATA_W-1];
            r_cnt <= DIV_CNT_W'(DATA_W - 1);
        end else if (i_cmd.div_step) begin
            if (!w_trial[DATA_W]) begin
                r_rem <= w_trial[DATA_W-1:0];
                r_quo <= {r_quo[DATA_W-2:0], 1'b1};
            end else begin
                r_rem <= w_rem_sh[DATA_W-1:0];
                r_quo <= {r_quo[DATA_W-2:0], 1'b0};
            end
            r_cnt <= r_cnt - DIV_CNT_W'(1);
        end
    end

    // Output register
    assign w_final_ok = (r_err == ST_OK) && (r_depth == DEPTH_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            if (r_err != ST_OK) begin
                r_out_status <= r_err;
            end else if (w_final_ok) begin
                r_out_status <= ST_OK;
            end else begin
                r_out_status <= ST_DEPTH;
            end
            r_out_result <= w_final_ok ? r_tos : '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_result    = r_out_result;

endmodule
